>>> sv/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg: shared types and tables of the UTF-8 stream decoder
// Byte classes, automaton transitions and the structs that pass between the
// per-byte step logic and the top level.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int CP_WIDTH    = 21;
  localparam int U16_WIDTH   = 16;
  localparam int TOT_WIDTH   = 32;

  typedef logic [3:0] dfa_state_t;
  typedef logic [3:0] byte_class_t;

  // Automaton states. The numbering is fixed by the transition table.
  localparam dfa_state_t ST_ACCEPT = 4'd0;
  localparam dfa_state_t ST_REJECT = 4'd1;
  localparam dfa_state_t ST_TAIL1  = 4'd2;  // one continuation byte left
  localparam dfa_state_t ST_TAIL2  = 4'd3;  // two continuation bytes left
  localparam dfa_state_t ST_E0     = 4'd4;  // after E0, needs A0..BF
  localparam dfa_state_t ST_ED     = 4'd5;  // after ED, needs 80..9F
  localparam dfa_state_t ST_F0     = 4'd6;  // after F0, needs 90..BF
  localparam dfa_state_t ST_F1F3   = 4'd7;  // after F1..F3
  localparam dfa_state_t ST_F4     = 4'd8;  // after F4, needs 80..8F

  // Byte classes.
  localparam byte_class_t CL_ASCII  = 4'd0;
  localparam byte_class_t CL_C80    = 4'd1;   // continuation 80..8F
  localparam byte_class_t CL_LEAD2  = 4'd2;
  localparam byte_class_t CL_LEAD3  = 4'd3;
  localparam byte_class_t CL_ED     = 4'd4;
  localparam byte_class_t CL_F4     = 4'd5;
  localparam byte_class_t CL_F1F3   = 4'd6;
  localparam byte_class_t CL_CA0    = 4'd7;   // continuation A0..BF
  localparam byte_class_t CL_BAD    = 4'd8;
  localparam byte_class_t CL_C90    = 4'd9;   // continuation 90..9F
  localparam byte_class_t CL_E0     = 4'd10;
  localparam byte_class_t CL_F0     = 4'd11;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef struct packed {
    dfa_state_t          dfa_state;
    logic [CP_WIDTH-1:0] partial;
    count_t              valid_cnt;
    count_t              error_cnt;
  } dec_state_t;

  typedef struct packed {
    logic                 codepoint_done;
    logic [CP_WIDTH-1:0]  codepoint;
    logic                 utf16_valid;
    logic [U16_WIDTH-1:0] utf16_word;
    logic                 reject;
    logic [TOT_WIDTH-1:0] valid_total;
    logic [TOT_WIDTH-1:0] error_total;
    logic                 end_of_string;
  } dec_result_t;

  function automatic byte_class_t byte_class(input logic [7:0] b);
    byte_class_t c;
    case (b) inside
      [8'h00:8'h7F]: c = CL_ASCII;
      [8'h80:8'h8F]: c = CL_C80;
      [8'h90:8'h9F]: c = CL_C90;
      [8'hA0:8'hBF]: c = CL_CA0;
      [8'hC2:8'hDF]: c = CL_LEAD2;
      8'hE0:         c = CL_E0;
      8'hED:         c = CL_ED;
      [8'hE1:8'hEF]: c = CL_LEAD3;
      8'hF0:         c = CL_F0;
      [8'hF1:8'hF3]: c = CL_F1F3;
      8'hF4:         c = CL_F4;
      default:       c = CL_BAD;
    endcase
    return c;
  endfunction

  function automatic dfa_state_t next_state(input dfa_state_t s, input byte_class_t c);
    dfa_state_t n;
    n = ST_REJECT;
    case (s)
      ST_ACCEPT: begin
        case (c)
          CL_ASCII: n = ST_ACCEPT;
          CL_LEAD2: n = ST_TAIL1;
          CL_LEAD3: n = ST_TAIL2;
          CL_ED:    n = ST_ED;
          CL_F4:    n = ST_F4;
          CL_F1F3:  n = ST_F1F3;
          CL_E0:    n = ST_E0;
          CL_F0:    n = ST_F0;
          default:  n = ST_REJECT;
        endcase
      end
      ST_TAIL1: if (c inside {CL_C80, CL_C90, CL_CA0}) n = ST_ACCEPT;
      ST_TAIL2: if (c inside {CL_C80, CL_C90, CL_CA0}) n = ST_TAIL1;
      ST_E0:    if (c == CL_CA0) n = ST_TAIL1;
      ST_ED:    if (c inside {CL_C80, CL_C90}) n = ST_TAIL1;
      ST_F0:    if (c inside {CL_C90, CL_CA0}) n = ST_TAIL2;
      ST_F1F3:  if (c inside {CL_C80, CL_C90, CL_CA0}) n = ST_TAIL2;
      ST_F4:    if (c == CL_C80) n = ST_TAIL2;
      default:  n = ST_REJECT;
    endcase
    return n;
  endfunction

endpackage

>>> sv/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder: validating byte-serial UTF-8 decoder
// Decodes one byte per transfer into code points, UTF-16 units and counts.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one byte (in_byte_in) and a flag
//   marking the final byte of a string (in_last_byte). Every byte produces
//   exactly one result transfer on out_valid/out_ready: a completed code
//   point with its UTF-16 unit for basic-plane values, a reject, or neither,
//   each with the saturating running counts of valid code points and errors.
//   An accepted byte's result is registered and on the output in the cycle
//   after. Throughput is one byte per cycle while the receiver is ready; the
//   decoder state and the result register update in the cycle of the input
//   transfer, set by the class lookup, transition and shift in one stage.
//   When the receiver stalls, the result register holds and in_ready drops
//   until the result is taken; a byte is accepted in the same cycle that
//   the waiting result leaves. After the result of a last byte, the
//   automaton, partial code point and counters return to zero.
//   Reset (rst_n low at a clock edge) empties the output and clears state.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_in,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_codepoint_done,
  output logic [20:0] out_codepoint,
  output logic        out_utf16_valid,
  output logic [15:0] out_utf16_word,
  output logic        out_reject,
  output logic [31:0] out_valid_total,
  output logic [31:0] out_error_total,
  output logic        out_end_of_string
);

  u8d_pkg::dec_state_t  state_r;
  u8d_pkg::dec_state_t  state_nxt;
  u8d_pkg::dec_result_t res_r;
  u8d_pkg::dec_result_t res_nxt;
  logic                 out_valid_r;
  logic                 in_xfer;

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  u8d_step u_step (
    .byte_in   (in_byte_in),
    .last_byte (in_last_byte),
    .cur       (state_r),
    .nxt       (state_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_codepoint_done = res_r.codepoint_done;
  assign out_codepoint      = res_r.codepoint;
  assign out_utf16_valid    = res_r.utf16_valid;
  assign out_utf16_word     = res_r.utf16_word;
  assign out_reject         = res_r.reject;
  assign out_valid_total    = res_r.valid_total;
  assign out_error_total    = res_r.error_total;
  assign out_end_of_string  = res_r.end_of_string;

  // A byte cannot both complete a code point and reject.
  a_done_excl_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_codepoint_done && out_reject))
    else $error("code point completed and rejected by the same byte");

  // A UTF-16 unit is only reported with a completed code point.
  a_utf16_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_utf16_valid |-> out_codepoint_done)
    else $error("UTF-16 unit without a completed code point");

  // The transfer of a last byte leaves the decoder fully cleared.
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_last_byte |=> (state_r == '0))
    else $error("state not cleared after the last byte of a string");

endmodule

>>> sv/u8d_step.sv
// ----------------------------------------------------------------------------
// u8d_step: per-byte decode logic
// Classifies one byte, advances the automaton, builds the code point and
// the running counts, and forms the result of that byte.
// ----------------------------------------------------------------------------
module u8d_step (
  input  logic [7:0]           byte_in,
  input  logic                 last_byte,
  input  u8d_pkg::dec_state_t  cur,
  output u8d_pkg::dec_state_t  nxt,
  output u8d_pkg::dec_result_t res
);

  u8d_pkg::byte_class_t          cls;
  u8d_pkg::dfa_state_t           st_step;
  logic [u8d_pkg::CP_WIDTH-1:0]  partial;
  logic [7:0]                    lead_mask;
  u8d_pkg::count_t               valid_cnt;
  u8d_pkg::count_t               error_cnt;
  logic                          done;
  logic                          rej;

  always_comb begin
    cls       = u8d_pkg::byte_class(byte_in);
    st_step   = u8d_pkg::next_state(cur.dfa_state, cls);
    lead_mask = 8'hFF >> cls;

    // A lead byte keeps only its payload bits; later bytes add six bits each.
    if (cur.dfa_state != u8d_pkg::ST_ACCEPT) begin
      partial = {cur.partial[u8d_pkg::CP_WIDTH-7:0], byte_in[5:0]};
    end else begin
      partial = {{(u8d_pkg::CP_WIDTH-8){1'b0}}, lead_mask & byte_in};
    end

    done = (st_step == u8d_pkg::ST_ACCEPT);
    rej  = (st_step == u8d_pkg::ST_REJECT);

    valid_cnt = cur.valid_cnt;
    error_cnt = cur.error_cnt;
    if (done && (cur.valid_cnt != '1)) valid_cnt = cur.valid_cnt + 1'b1;
    if (rej && (cur.error_cnt != '1))  error_cnt = cur.error_cnt + 1'b1;

    res.codepoint_done = done;
    res.codepoint      = done ? partial : '0;
    res.utf16_valid    = done && (partial[u8d_pkg::CP_WIDTH-1:u8d_pkg::U16_WIDTH] == '0);
    res.utf16_word     = res.utf16_valid ? partial[u8d_pkg::U16_WIDTH-1:0] : '0;
    res.reject         = rej;
    res.valid_total    = u8d_pkg::TOT_WIDTH'(valid_cnt);
    res.error_total    = u8d_pkg::TOT_WIDTH'(error_cnt);
    res.end_of_string  = last_byte;

    // A rejected sequence resyncs at accept; the end of a string clears all.
    if (last_byte) begin
      nxt = '0;
    end else begin
      nxt.dfa_state = rej ? u8d_pkg::ST_ACCEPT : st_step;
      nxt.partial   = partial;
      nxt.valid_cnt = valid_cnt;
      nxt.error_cnt = error_cnt;
    end
  end

endmodule
